[rtl/core/scd_pkg.sv]
// Shared types and constants of the sector cache clock directory.
// Depends on nothing; the datapath, controller, top level and testbench use it by scoped names.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int PIN_BITS_DEF = 8;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_REL   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_WB    = 2'd2,
    KIND_FAIL  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_LK_RD,
    ST_LK_CHK,
    ST_HIT,
    ST_SW_RD,
    ST_SW_CHK,
    ST_WB,
    ST_FILL,
    ST_GRANT,
    ST_FAIL,
    ST_FL_RD,
    ST_FL_CHK,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  rd;
    logic  idx_inc;
    logic  sw_init;
    logic  sw_adv;
    logic  take_new;
    logic  take_victim;
    logic  hit_sel;
    logic  wr_hit;
    logic  wr_clracc;
    logic  wr_clrdirty;
    logic  wr_fill;
    logic  ahead_init;
    logic  push;
    kind_t kind;
    logic  finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       in_dirty;
    logic       ahead;
    logic       idx_end;
    logic       full;
    logic       tag_hit;
    logic       acc;
    logic       pinned;
    logic       mdirty;
    logic       step_end;
    logic       pend_v;
    logic       can_push;
  } sts_t;

endpackage

[rtl/core/scd_req_if.sv]
// Request channel of the sector cache directory: valid/ready plus one request item.
// Depends on nothing.
`timescale 1ns / 1ps

interface scd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] sector;
  logic        dirty;

  modport source (output valid, cmd, sector, dirty, input ready);
  modport sink   (input valid, cmd, sector, dirty, output ready);
endinterface

[rtl/core/scd_rsp_if.sv]
// Result channel of the sector cache directory: valid/ready plus one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface scd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  slot;
  logic [31:0] target_sector;
  logic        last;

  modport source (output valid, kind, slot, target_sector, last, input ready);
  modport sink   (input valid, kind, slot, target_sector, last, output ready);
endinterface

[rtl/core/scd_dp.sv]
// Datapath of the sector cache directory: tag and metadata memories, scan
// counters, clock hand, pending result and output register. Uses scd_pkg.
`timescale 1ns / 1ps

module scd_dp #(
  parameter int SLOTS    = scd_pkg::SLOTS_DEF,
  parameter int PIN_BITS = scd_pkg::PIN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  scd_pkg::ctl_t      ctl,
  output scd_pkg::sts_t      sts,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_sector,
  input  logic               in_dirty,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_slot,
  output logic [31:0]        out_target,
  output logic               out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = $clog2(2 * SLOTS + 1);
  localparam int MW = PIN_BITS + 2;

  // metadata word: dirty, accessed, pin count
  logic [31:0]   tag_mem  [SLOTS];
  logic [MW-1:0] meta_mem [SLOTS];
  logic [31:0]   tag_q;
  logic [MW-1:0] meta_q;

  logic [1:0]    cmd_q;
  logic [31:0]   sector_q;
  logic          dirty_q;
  logic          ahead;
  logic [31:0]   cur;
  logic [CW-1:0] idx;
  logic [SW-1:0] step;
  logic [CW-1:0] occ;
  logic [IW-1:0] hand;
  logic [IW-1:0] s;

  logic          pend_v;
  logic [1:0]    pend_kind;
  logic [IW-1:0] pend_slot;
  logic [31:0]   pend_tgt;

  logic [IW-1:0] idx_a;
  logic [IW-1:0] idx_wrap;
  logic          q_dirty, q_acc;
  logic [PIN_BITS-1:0] q_pins;
  logic [PIN_BITS-1:0] hit_pins;
  logic          hit_dirty;
  logic          meta_we;
  logic [IW-1:0] meta_wa;
  logic [MW-1:0] meta_wd;
  logic          move;
  logic [1:0]    new_kind;
  logic [IW-1:0] new_slot;
  logic [31:0]   new_tgt;
  logic [IW+5:0] slot_ext;

  assign idx_a    = idx[IW-1:0];
  assign idx_wrap = (idx_a == IW'(SLOTS - 1)) ? '0 : idx_a + IW'(1);
  assign q_dirty  = meta_q[MW-1];
  assign q_acc    = meta_q[MW-2];
  assign q_pins   = meta_q[PIN_BITS-1:0];

  always_comb begin
    hit_dirty = q_dirty;
    hit_pins  = q_pins;
    if (cmd_q == scd_pkg::CMD_REL) begin
      hit_pins = (q_pins == '0) ? q_pins : q_pins - PIN_BITS'(1);
    end else if (!ahead) begin
      hit_dirty = q_dirty | dirty_q;
      hit_pins  = (q_pins == '1) ? q_pins : q_pins + PIN_BITS'(1);
    end
  end

  always_comb begin
    meta_we = ctl.wr_hit | ctl.wr_clracc | ctl.wr_clrdirty | ctl.wr_fill;
    meta_wa = idx_a;
    meta_wd = meta_q;
    if (ctl.wr_fill) begin
      meta_wa = s;
      meta_wd = {~ahead & dirty_q, 1'b1, ahead ? PIN_BITS'(0) : PIN_BITS'(1)};
    end else if (ctl.wr_hit) begin
      meta_wd = {hit_dirty, 1'b1, hit_pins};
    end else if (ctl.wr_clracc) begin
      meta_wd = {q_dirty, 1'b0, q_pins};
    end else if (ctl.wr_clrdirty) begin
      meta_wd = {1'b0, q_acc, q_pins};
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (ctl.wr_fill) begin
      tag_mem[s] <= cur;
    end
    if (ctl.rd) begin
      meta_q <= meta_mem[idx_a];
      tag_q  <= tag_mem[idx_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      hand <= '0;
    end else begin
      if (ctl.take_new) begin
        occ <= occ + CW'(1);
      end
      if (ctl.take_victim) begin
        hand <= idx_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= in_cmd;
      sector_q <= in_sector;
      dirty_q  <= in_dirty;
      cur      <= in_sector;
      ahead    <= 1'b0;
      idx      <= '0;
    end else if (ctl.ahead_init) begin
      cur   <= sector_q + 32'd1;
      ahead <= 1'b1;
      idx   <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (ctl.sw_init) begin
      idx  <= CW'(hand);
      step <= '0;
    end else if (ctl.sw_adv) begin
      idx  <= CW'(idx_wrap);
      step <= step + SW'(1);
    end
    if (ctl.take_new) begin
      s <= occ[IW-1:0];
    end else if (ctl.take_victim || ctl.hit_sel) begin
      s <= idx_a;
    end
  end

  always_comb begin
    new_kind = ctl.kind;
    new_slot = s;
    new_tgt  = cur;
    unique case (ctl.kind)
      scd_pkg::KIND_GRANT: new_tgt  = sector_q;
      scd_pkg::KIND_FILL:  new_tgt  = cur;
      scd_pkg::KIND_WB: begin
        new_slot = idx_a;
        new_tgt  = tag_q;
      end
      scd_pkg::KIND_FAIL:  new_slot = '0;
      default: new_tgt = cur;
    endcase
  end

  // hold one result back so the final one can be marked last
  assign move = pend_v & (ctl.push | ctl.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.push) begin
        pend_v <= 1'b1;
      end else if (ctl.finish) begin
        pend_v <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      pend_kind <= new_kind;
      pend_slot <= new_slot;
      pend_tgt  <= new_tgt;
    end
    if (move) begin
      out_kind   <= pend_kind;
      out_slot   <= slot_ext[5:0];
      out_target <= pend_tgt;
      out_last   <= ctl.finish;
    end
  end

  assign slot_ext = {6'b0, pend_slot};

  always_comb begin
    sts.cmd      = cmd_q;
    sts.in_dirty = dirty_q;
    sts.ahead    = ahead;
    sts.idx_end  = (idx >= occ);
    sts.full     = (occ == CW'(SLOTS));
    sts.tag_hit  = (tag_q == cur);
    sts.acc      = q_acc;
    sts.pinned   = (q_pins != '0);
    sts.mdirty   = q_dirty;
    sts.step_end = (step == SW'(2 * SLOTS));
    sts.pend_v   = pend_v;
    sts.can_push = ~pend_v | ~out_valid | out_ready;
  end

endmodule

[rtl/core/scd_ctrl.sv]
// Controller state machine of the sector cache directory: sequences lookup,
// clock sweep, fill, grant, read-ahead and flush. Uses scd_pkg.
`timescale 1ns / 1ps

module scd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  scd_pkg::sts_t sts,
  output scd_pkg::ctl_t ctl
);

  scd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scd_pkg::ST_IDLE:   if (in_valid) state_next = scd_pkg::ST_DISP;
      scd_pkg::ST_DISP: begin
        if (sts.cmd == scd_pkg::CMD_GET || sts.cmd == scd_pkg::CMD_REL) begin
          state_next = scd_pkg::ST_LK_RD;
        end else if (sts.cmd == scd_pkg::CMD_FLUSH) begin
          state_next = scd_pkg::ST_FL_RD;
        end else begin
          state_next = scd_pkg::ST_FIN;
        end
      end
      scd_pkg::ST_LK_RD: begin
        if (!sts.idx_end)                    state_next = scd_pkg::ST_LK_CHK;
        else if (sts.cmd == scd_pkg::CMD_REL) state_next = scd_pkg::ST_FIN;
        else if (sts.full)                   state_next = scd_pkg::ST_SW_RD;
        else                                 state_next = scd_pkg::ST_FILL;
      end
      scd_pkg::ST_LK_CHK:
        state_next = sts.tag_hit ? scd_pkg::ST_HIT : scd_pkg::ST_LK_RD;
      scd_pkg::ST_HIT:
        state_next = (sts.ahead || sts.cmd == scd_pkg::CMD_REL) ?
                     scd_pkg::ST_FIN : scd_pkg::ST_GRANT;
      scd_pkg::ST_SW_RD:
        state_next = sts.step_end ? scd_pkg::ST_FAIL : scd_pkg::ST_SW_CHK;
      scd_pkg::ST_SW_CHK: begin
        if (sts.acc || sts.pinned) state_next = scd_pkg::ST_SW_RD;
        else if (sts.mdirty)       state_next = scd_pkg::ST_WB;
        else                       state_next = scd_pkg::ST_FILL;
      end
      scd_pkg::ST_WB:   if (sts.can_push) state_next = scd_pkg::ST_FILL;
      scd_pkg::ST_FILL:
        if (sts.can_push) state_next = sts.ahead ? scd_pkg::ST_FIN : scd_pkg::ST_GRANT;
      scd_pkg::ST_GRANT:
        if (sts.can_push) state_next = sts.in_dirty ? scd_pkg::ST_FIN : scd_pkg::ST_LK_RD;
      scd_pkg::ST_FAIL: if (sts.can_push) state_next = scd_pkg::ST_FIN;
      scd_pkg::ST_FL_RD:
        state_next = sts.idx_end ? scd_pkg::ST_FIN : scd_pkg::ST_FL_CHK;
      scd_pkg::ST_FL_CHK:
        if (!sts.mdirty || sts.can_push) state_next = scd_pkg::ST_FL_RD;
      scd_pkg::ST_FIN:
        if (!sts.pend_v || sts.can_push) state_next = scd_pkg::ST_IDLE;
      default: state_next = scd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.kind = scd_pkg::KIND_GRANT;
    in_ready = 1'b0;
    unique case (state)
      scd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      scd_pkg::ST_DISP: ;
      scd_pkg::ST_LK_RD: begin
        if (!sts.idx_end) begin
          ctl.rd = 1'b1;
        end else if (sts.cmd != scd_pkg::CMD_REL) begin
          ctl.sw_init  = sts.full;
          ctl.take_new = ~sts.full;
        end
      end
      scd_pkg::ST_LK_CHK: ctl.idx_inc = ~sts.tag_hit;
      scd_pkg::ST_HIT: begin
        ctl.wr_hit  = 1'b1;
        ctl.hit_sel = 1'b1;
      end
      scd_pkg::ST_SW_RD: ctl.rd = ~sts.step_end;
      scd_pkg::ST_SW_CHK: begin
        if (sts.acc) begin
          ctl.wr_clracc = 1'b1;
          ctl.sw_adv    = 1'b1;
        end else if (sts.pinned) begin
          ctl.sw_adv = 1'b1;
        end else begin
          ctl.take_victim = 1'b1;
        end
      end
      scd_pkg::ST_WB: begin
        ctl.kind = scd_pkg::KIND_WB;
        ctl.push = sts.can_push;
      end
      scd_pkg::ST_FILL: begin
        ctl.kind    = scd_pkg::KIND_FILL;
        ctl.push    = sts.can_push;
        ctl.wr_fill = sts.can_push;
      end
      scd_pkg::ST_GRANT: begin
        ctl.kind       = scd_pkg::KIND_GRANT;
        ctl.push       = sts.can_push;
        ctl.ahead_init = sts.can_push & ~sts.in_dirty;
      end
      scd_pkg::ST_FAIL: begin
        ctl.kind = scd_pkg::KIND_FAIL;
        ctl.push = sts.can_push;
      end
      scd_pkg::ST_FL_RD: ctl.rd = ~sts.idx_end;
      scd_pkg::ST_FL_CHK: begin
        ctl.kind = scd_pkg::KIND_WB;
        if (!sts.mdirty) begin
          ctl.idx_inc = 1'b1;
        end else if (sts.can_push) begin
          ctl.push        = 1'b1;
          ctl.wr_clrdirty = 1'b1;
          ctl.idx_inc     = 1'b1;
        end
      end
      scd_pkg::ST_FIN: ctl.finish = sts.pend_v & sts.can_push;
      default: ;
    endcase
  end

endmodule

[rtl/core/sector_cache_clock_directory_unit.sv]
// Top level of the sector cache directory with clock replacement.
// Depends on scd_pkg, scd_req_if, scd_rsp_if, scd_ctrl and scd_dp.
`timescale 1ns / 1ps
//
//  channel | dir | payload                          | role
//  --------+-----+----------------------------------+-----------------------------
//  req     | in  | cmd, sector, dirty               | get / release / flush item
//  rsp     | out | kind, slot, target_sector, last  | grant, fill, write-back, fail
//
// Each slot visited is read, then checked (LK_RD then LK_CHK, SW_RD then SW_CHK),
// as the tag and metadata memories are read one slot at a time. A get looks up the
// occupied slots, then on a miss claims a fresh slot or, with a full directory,
// sweeps the clock for a victim, then pushes its results; a read-ahead repeats the lookup.
// Reset clears the state machine, fill count, clock hand and result valids;
// tag and metadata memories need no clearing since only filled slots are read.
// A stalled rsp holds the controller only when a result must be pushed or the last
// one sent while the pending and output registers are full. One item at a time.

module sector_cache_clock_directory_unit #(
  parameter int SLOTS    = scd_pkg::SLOTS_DEF,
  parameter int PIN_BITS = scd_pkg::PIN_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  scd_req_if.sink   req,
  scd_rsp_if.source rsp
);

  scd_pkg::ctl_t ctl;
  scd_pkg::sts_t sts;

  // controller: accepts the item and drives the datapath commands
  scd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath: directory memories, sweep counters and result registers
  scd_dp #(
    .SLOTS    (SLOTS),
    .PIN_BITS (PIN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (req.cmd),
    .in_sector  (req.sector),
    .in_dirty   (req.dirty),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_kind   (rsp.kind),
    .out_slot   (rsp.slot),
    .out_target (rsp.target_sector),
    .out_last   (rsp.last)
  );

endmodule

[tb/sv/tb_sector_cache_clock_directory_unit.sv]
// Self-checking testbench of the sector cache clock directory unit.
// Depends on scd_pkg, scd_req_if, scd_rsp_if and the unit itself.
`timescale 1ns / 1ps

module tb_sector_cache_clock_directory_unit;

  localparam int NSLOT  = scd_pkg::SLOTS_DEF;
  localparam int PINMAX = (1 << scd_pkg::PIN_BITS_DEF) - 1;

  typedef struct packed {
    scd_pkg::cmd_t cmd;
    logic [31:0]   sector;
    logic          dirty;
  } request_t;

  typedef struct packed {
    scd_pkg::kind_t kind;
    logic [5:0]     slot;
    logic [31:0]    target;
    logic           last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scd_req_if req ();
  scd_rsp_if rsp ();

  sector_cache_clock_directory_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Directory mirror: same state as the unit keeps, updated per accepted item.
  logic [31:0] dir_tag [NSLOT];
  logic        dir_dirty [NSLOT];
  logic        dir_acc [NSLOT];
  int          dir_pins [NSLOT];
  int          dir_used;
  int          dir_hand;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  result_t  item_results[$];
  request_t cur_req;
  int       send_gap   = 0;
  int       recv_stall = 0;
  int       in_acc_n   = 0;
  int       in_seen_n  = 0;
  int       out_acc_n  = 0;
  int       out_seen_n = 0;
  bit       busy       = 1'b0;
  bit       quiet      = 1'b0;
  bit       failed     = 1'b0;

  task automatic add_result(input scd_pkg::kind_t k, input int s, input logic [31:0] t);
    result_t r;
    r.kind   = k;
    r.slot   = s[5:0];
    r.target = t;
    r.last   = 1'b0;
    item_results.push_back(r);
  endtask

  // Search the used slots; a hit marks the slot accessed.
  task automatic find_sector(input logic [31:0] sec, output int idx);
    idx = -1;
    for (int i = 0; i < dir_used; i++) begin
      if (dir_tag[i] == sec) begin
        dir_acc[i] = 1'b1;
        idx = i;
        break;
      end
    end
  endtask

  // Claim a fresh slot or sweep the clock for a victim; report failure
  // when two full sweeps find only pinned slots.
  task automatic claim_slot(input logic [31:0] sec, input logic d, input int pins,
                            output int idx);
    int  h;
    bit  found;
    idx   = 0;
    found = 0;
    if (dir_used < NSLOT) begin
      idx = dir_used;
      dir_used++;
      found = 1;
    end else begin
      h = dir_hand;
      for (int step = 0; step < 2 * NSLOT; step++) begin
        if (dir_acc[h]) begin
          dir_acc[h] = 1'b0;
        end else if (dir_pins[h] == 0) begin
          if (dir_dirty[h]) add_result(scd_pkg::KIND_WB, h, dir_tag[h]);
          dir_hand = (h + 1) % NSLOT;
          idx = h;
          found = 1;
          break;
        end
        h = (h + 1) % NSLOT;
      end
    end
    if (!found) begin
      add_result(scd_pkg::KIND_FAIL, 0, sec);
      idx = -1;
    end else begin
      dir_tag[idx]   = sec;
      dir_dirty[idx] = d;
      dir_acc[idx]   = 1'b1;
      dir_pins[idx]  = pins;
      add_result(scd_pkg::KIND_FILL, idx, sec);
    end
  endtask

  task automatic predict_directory(input request_t r);
    int s;
    int a;
    item_results.delete();
    case (r.cmd)
      scd_pkg::CMD_GET: begin
        find_sector(r.sector, s);
        if (s >= 0) begin
          dir_dirty[s] = dir_dirty[s] | r.dirty;
          if (dir_pins[s] < PINMAX) dir_pins[s]++;
          dir_acc[s] = 1'b1;
        end else begin
          claim_slot(r.sector, r.dirty, 1, s);
        end
        if (s >= 0) begin
          add_result(scd_pkg::KIND_GRANT, s, r.sector);
          if (!r.dirty) begin
            // read ahead the next sector, unpinned
            find_sector(r.sector + 32'd1, a);
            if (a < 0) claim_slot(r.sector + 32'd1, 1'b0, 0, a);
          end
        end
      end
      scd_pkg::CMD_REL: begin
        find_sector(r.sector, s);
        if (s >= 0 && dir_pins[s] > 0) dir_pins[s]--;
      end
      scd_pkg::CMD_FLUSH: begin
        for (int i = 0; i < dir_used; i++) begin
          if (dir_dirty[i]) begin
            add_result(scd_pkg::KIND_WB, i, dir_tag[i]);
            dir_dirty[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[i]) expected_results.push_back(item_results[i]);
  endtask

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic request_t mk(input scd_pkg::cmd_t c, input logic [31:0] s,
                                  input logic d);
    request_t r;
    r.cmd    = c;
    r.sector = s;
    r.dirty  = d;
    return r;
  endfunction

  // Driver: present items at the falling edge, hold until accepted, then
  // idle for a drawn number of cycles before the next item.
  always @(negedge clk) begin
    if (rst) begin
      req.valid  <= 1'b0;
      req.cmd    <= scd_pkg::CMD_NONE;
      req.sector <= '0;
      req.dirty  <= 1'b0;
    end else begin
      if (busy && in_seen_n != in_acc_n) begin
        in_seen_n = in_acc_n;
        busy      = 1'b0;
        send_gap  = draw_wait();
      end
      if (!busy) begin
        if (send_gap == 0 && pending_reqs.size() > 0) begin
          cur_req    = pending_reqs.pop_front();
          busy       = 1'b1;
          req.valid  <= 1'b1;
          req.cmd    <= cur_req.cmd;
          req.sector <= cur_req.sector;
          req.dirty  <= cur_req.dirty;
        end else begin
          if (send_gap > 0) send_gap = send_gap - 1;
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Request monitor: predict on acceptance.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      predict_directory(cur_req);
      in_acc_n = in_acc_n + 1;
    end
  end

  // Result side: after each accepted result, hold ready low for a drawn count.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (out_seen_n != out_acc_n) begin
        out_seen_n = out_acc_n;
        recv_stall = draw_wait();
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      out_acc_n = out_acc_n + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d slot=%0d sector=%h last=%0d", $time,
                 rsp.kind, rsp.slot, rsp.target_sector, rsp.last);
        failed = 1;
      end else begin
        want = expected_results.pop_front();
        if (rsp.kind !== want.kind || rsp.slot !== want.slot ||
            rsp.target_sector !== want.target || rsp.last !== want.last) begin
          $display("%0t: mismatch exp kind=%0d slot=%0d sector=%h last=%0d", $time,
                   want.kind, want.slot, want.target, want.last);
          $display("%0t:          got kind=%0d slot=%0d sector=%h last=%0d", $time,
                   rsp.kind, rsp.slot, rsp.target_sector, rsp.last);
          failed = 1;
        end
      end
    end
  end

  // Flip between busy stretches and stretches with no idling.
  always begin
    repeat (400) @(posedge clk);
    quiet = ~quiet;
  end

  initial begin
    int          n;
    int          n_items;
    logic [31:0] base;
    for (int i = 0; i < NSLOT; i++) begin
      dir_tag[i]   = '0;
      dir_dirty[i] = 1'b0;
      dir_acc[i]   = 1'b0;
      dir_pins[i]  = 0;
    end
    dir_used = 0;
    dir_hand = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every command, wrap of read-ahead, absent
    // and unpinned releases, empty flush, unused command.
    pending_reqs.push_back(mk(scd_pkg::CMD_FLUSH, 32'h0, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_REL, 32'h1234, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_GET, 32'hFFFF_FFFF, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_GET, 32'h0, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_GET, 32'hAAAA_5555, 1'b1));
    pending_reqs.push_back(mk(scd_pkg::CMD_GET, 32'hAAAA_5555, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_GET, 32'h5555_AAAA, 1'b1));
    pending_reqs.push_back(mk(scd_pkg::CMD_REL, 32'h0000_0001, 1'b1));
    pending_reqs.push_back(mk(scd_pkg::CMD_REL, 32'h0000_0001, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_REL, 32'hFFFF_FFFF, 1'b0));
    pending_reqs.push_back(mk(scd_pkg::CMD_NONE, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(scd_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(scd_pkg::CMD_FLUSH, 32'h0, 1'b0));

    // Pin every slot with write gets, overflow into eviction failures,
    // then release them.
    base = $urandom;
    for (int i = 0; i < NSLOT + 3; i++)
      pending_reqs.push_back(mk(scd_pkg::CMD_GET, base + 32'(i), 1'b1));
    for (int i = 0; i < NSLOT; i++)
      pending_reqs.push_back(mk(scd_pkg::CMD_REL, base + 32'(i),
                                1'($urandom_range(0, 1))));

    // Random: mostly gets over a pool a bit larger than the cache so hits,
    // evictions and write-backs mix; some releases, flushes and noise.
    base = $urandom;
    for (int i = 0; i < 116; i++) begin
      n = $urandom_range(0, 99);
      if (n < 60)
        pending_reqs.push_back(mk(scd_pkg::CMD_GET, base + $urandom_range(0, 90),
                                  1'($urandom_range(0, 1))));
      else if (n < 82)
        pending_reqs.push_back(mk(scd_pkg::CMD_REL, base + $urandom_range(0, 90),
                                  1'($urandom_range(0, 1))));
      else if (n < 88)
        pending_reqs.push_back(mk(scd_pkg::CMD_FLUSH, $urandom, 1'($urandom_range(0, 1))));
      else if (n < 96)
        pending_reqs.push_back(mk(scd_pkg::CMD_GET, $urandom, 1'($urandom_range(0, 1))));
      else
        pending_reqs.push_back(mk(scd_pkg::CMD_NONE, $urandom, 1'($urandom_range(0, 1))));
    end
    n_items = pending_reqs.size();

    wait (in_acc_n == n_items);
    wait (expected_results.size() == 0);
    repeat (1000) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("%0t: timeout, %0d items pending, %0d results outstanding", $time,
             pending_reqs.size(), expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
